@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset as disable
`define SBS_ASSERT(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error(msg);

// same, on the block's own clock and reset names
`define SBS_ASSERT_CLK(lbl, prop, msg) \
    `SBS_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

@@ hw/rtl/sbs_pkg.sv @@
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants of the signature byte scanner.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int NUM_SIGS_DEF    = 8;
    localparam int MAX_SIG_LEN_DEF = 64;
    localparam int MAX_RESULTS     = 8;
    localparam int RES_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] SCAN_LIMIT_RST = 16'd10000;

    localparam int APB_ADDR_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_WR_BYTE    = 2'd0,
        CMD_SET_LEN    = 2'd1,
        CMD_NEW_STREAM = 2'd2,
        CMD_SCAN       = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_COMPARE,
        ST_REDUCE,
        ST_REPORT
    } state_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/signature_byte_scanner.sv @@
// ----------------------------------------------------------------------------
// signature_byte_scanner
// Multi-signature byte stream matcher built from a chain of window cells.
// ----------------------------------------------------------------------------
// Input beats on s_*: s_tuser carries the command (write signature byte, set
// slot length, start new stream, scan byte), s_tdata the operands. Report
// beats on m_*: one per matching slot in slot order, m_tlast on the final
// report of a byte. scan_limit is written over the APB port at address 0.
// Load and new-stream beats leave s_tready high for the next beat. Setting
// a slot length rotates that slot's signature bytes round the cell chain one
// position per cycle until its rotation count matches the new length. A
// scanned byte shifts into the window, is compared in every cell on the next
// cycle, reduced over the chain on the one after, and its reports are then
// loaded into the output register in slot order. A byte past scan_limit is
// accepted and dropped, and the next beat can follow straight away.
// When m_tready is low the report walk waits on the output register, and
// s_tready stays low until all reports of the byte have been loaded.
// Reset clears slot lengths, stream position and the output; scan_limit
// returns to 10000. Signature bytes are not cleared.
// ----------------------------------------------------------------------------
module signature_byte_scanner #(
    parameter int NUM_SIGS    = sbs_pkg::NUM_SIGS_DEF,
    parameter int MAX_SIG_LEN = sbs_pkg::MAX_SIG_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbs_pkg::IN_DATA_W-1:0]  s_tdata,   // slot, byte_index, value, sig_length
    input  logic [1:0]                     s_tuser,   // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sbs_pkg::OUT_DATA_W-1:0] m_tdata,   // match_slot, start_offset, match_length
    output logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import sbs_pkg::*;

    localparam int SLOT_W = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
    localparam int LEN_W  = $clog2(MAX_SIG_LEN + 1);
    localparam int CELL_W = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
    localparam int SUM_W  = $clog2(2 * MAX_SIG_LEN);

    state_t                         state_reg, state_next;
    logic [15:0]                    position_reg;
    logic [15:0]                    scan_limit_reg;
    logic [NUM_SIGS-1:0][CELL_W-1:0] rot_reg;
    logic [NUM_SIGS-1:0][LEN_W-1:0] lens_reg;
    logic [SLOT_W-1:0]              rot_slot_reg;
    logic [CELL_W-1:0]              rot_tgt_reg;

    // beat fields
    cmd_t              in_cmd;
    logic [2:0]        in_slot;
    logic [5:0]        in_bidx;
    logic [7:0]        in_value;
    logic [6:0]        in_slen;
    logic [SLOT_W-1:0] slot_idx;
    logic              slot_ok;
    logic              bidx_ok;
    logic              accept;

    logic [LEN_W-1:0]  slen_sat;
    logic [CELL_W-1:0] len_rot;
    logic [CELL_W-1:0] rot_cur;
    logic [SUM_W-1:0]  wr_sum;
    logic [CELL_W-1:0] wr_cell;

    logic              wr_go;
    logic              len_go;
    logic              scan_go;
    logic              new_go;
    logic              rot_step;
    logic [NUM_SIGS-1:0] rot_en;

    logic [NUM_SIGS-1:0] match_vec;
    logic              rpt_busy;
    logic              cfg_wr;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_slot  = s_tdata[2:0];
    assign in_bidx  = s_tdata[8:3];
    assign in_value = s_tdata[16:9];
    assign in_slen  = s_tdata[23:17];
    assign slot_idx = SLOT_W'(in_slot);
    assign slot_ok  = ({4'b0, in_slot} < 7'(NUM_SIGS));
    assign bidx_ok  = ({3'b0, in_bidx} < 9'(MAX_SIG_LEN));
    assign accept   = s_tvalid && s_tready;

    // cell j holds signature byte (rot - 1 - j) mod MAX_SIG_LEN of each slot
    always_comb
    begin
        slen_sat = ({2'b0, in_slen} > 9'(MAX_SIG_LEN)) ? LEN_W'(MAX_SIG_LEN)
                                                       : LEN_W'(in_slen);
        len_rot  = (slen_sat == LEN_W'(MAX_SIG_LEN)) ? '0 : CELL_W'(slen_sat);
        wr_sum   = SUM_W'(rot_reg[slot_idx]) + SUM_W'(MAX_SIG_LEN - 1)
                   - SUM_W'(CELL_W'(in_bidx));
        wr_cell  = (wr_sum >= SUM_W'(MAX_SIG_LEN)) ? CELL_W'(wr_sum - SUM_W'(MAX_SIG_LEN))
                                                   : CELL_W'(wr_sum);
        rot_cur  = rot_reg[rot_slot_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        wr_go      = 1'b0;
        len_go     = 1'b0;
        scan_go    = 1'b0;
        new_go     = 1'b0;
        rot_step   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_WR_BYTE:
                        begin
                            wr_go = slot_ok && bidx_ok;
                        end
                        CMD_SET_LEN:
                        begin
                            if (slot_ok)
                            begin
                                len_go     = 1'b1;
                                state_next = ST_ROTATE;
                            end
                        end
                        CMD_NEW_STREAM:
                        begin
                            new_go = 1'b1;
                        end
                        CMD_SCAN:
                        begin
                            if (position_reg < scan_limit_reg)
                            begin
                                scan_go    = 1'b1;
                                state_next = ST_COMPARE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROTATE:
            begin
                if (rot_cur == rot_tgt_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rot_step = 1'b1;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (!rpt_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            rot_reg      <= '0;
            lens_reg     <= '0;
            rot_slot_reg <= '0;
            rot_tgt_reg  <= '0;
        end
        else
        begin
            if (new_go)
            begin
                position_reg <= '0;
            end
            else if (scan_go)
            begin
                position_reg <= position_reg + 16'd1;
            end
            if (len_go)
            begin
                lens_reg[slot_idx] <= slen_sat;
                rot_slot_reg       <= slot_idx;
                rot_tgt_reg        <= len_rot;
            end
            if (rot_step)
            begin
                rot_reg[rot_slot_reg] <= (rot_cur == CELL_W'(MAX_SIG_LEN - 1))
                                         ? '0 : rot_cur + 1'b1;
            end
        end
    end

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg <= SCAN_LIMIT_RST;
        end
        else if (cfg_wr && (paddr[APB_ADDR_W-1:2] == '0))
        begin
            scan_limit_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == '0) ? {16'b0, scan_limit_reg} : 32'b0;

    // cell chain
    logic [7:0]               win_chain [MAX_SIG_LEN];
    logic [NUM_SIGS-1:0][7:0] sig_chain [MAX_SIG_LEN];
    logic [NUM_SIGS-1:0]      ok_cells  [MAX_SIG_LEN];
    cell_ctrl_t               cell_ctrl [MAX_SIG_LEN];

    always_comb
    begin
        rot_en = '0;
        if (rot_step)
        begin
            rot_en[rot_slot_reg] = 1'b1;
        end
    end

    for (genvar j = 0; j < MAX_SIG_LEN; j++)
    begin : g_cell
        logic [7:0] win_feed;

        if (j == 0)
        begin : g_head
            assign win_feed = in_value;
        end
        else
        begin : g_body
            assign win_feed = win_chain[j-1];
        end

        assign cell_ctrl[j].shift = scan_go;
        assign cell_ctrl[j].wr    = wr_go && (wr_cell == CELL_W'(j));

        sbs_cell #(
            .NUM_SIGS (NUM_SIGS),
            .SLOT_W   (SLOT_W),
            .LEN_W    (LEN_W),
            .CELL_IDX (j)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl[j]),
            .wr_slot  (slot_idx),
            .wr_value (in_value),
            .win_in   (win_feed),
            .win_out  (win_chain[j]),
            .rot_en   (rot_en),
            .sig_in   (sig_chain[(j + MAX_SIG_LEN - 1) % MAX_SIG_LEN]),
            .sig_out  (sig_chain[j]),
            .lens     (lens_reg),
            .ok       (ok_cells[j])
        );
    end

    // and over the chain per slot, plus length checks against bytes seen
    always_comb
    begin
        logic [MAX_SIG_LEN-1:0] col;
        for (int s = 0; s < NUM_SIGS; s++)
        begin
            for (int j = 0; j < MAX_SIG_LEN; j++)
            begin
                col[j] = ok_cells[j][s];
            end
            match_vec[s] = (&col) && (lens_reg[s] != '0)
                           && (16'(lens_reg[s]) <= position_reg);
        end
    end

    sbs_report #(
        .NUM_SIGS (NUM_SIGS),
        .SLOT_W   (SLOT_W),
        .LEN_W    (LEN_W)
    ) u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == ST_REDUCE),
        .match_vec (match_vec),
        .count_in  (position_reg),
        .lens      (lens_reg),
        .busy      (rpt_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hw/rtl/sbs_cell.sv @@
// ----------------------------------------------------------------------------
// sbs_cell
// One window position: holds a stream byte and one signature byte per slot,
// shifts both along the chain and flags per slot whether this position agrees.
// ----------------------------------------------------------------------------
module sbs_cell #(
    parameter int NUM_SIGS = 8,
    parameter int SLOT_W   = 3,
    parameter int LEN_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                           clk,
    input  sbs_pkg::cell_ctrl_t            ctrl,
    input  logic [SLOT_W-1:0]              wr_slot,
    input  logic [7:0]                     wr_value,
    input  logic [7:0]                     win_in,
    output logic [7:0]                     win_out,
    input  logic [NUM_SIGS-1:0]            rot_en,
    input  logic [NUM_SIGS-1:0][7:0]       sig_in,
    output logic [NUM_SIGS-1:0][7:0]       sig_out,
    input  logic [NUM_SIGS-1:0][LEN_W-1:0] lens,
    output logic [NUM_SIGS-1:0]            ok
);
    import sbs_pkg::*;

    logic [7:0]                win_reg;
    logic [NUM_SIGS-1:0][7:0]  sig_reg;
    logic [NUM_SIGS-1:0]       ok_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            win_reg <= win_in;
        end
        for (int s = 0; s < NUM_SIGS; s++)
        begin
            if (rot_en[s])
            begin
                sig_reg[s] <= sig_in[s];
            end
            else if (ctrl.wr && (wr_slot == SLOT_W'(s)))
            begin
                sig_reg[s] <= wr_value;
            end
            // positions at or beyond the slot length do not take part
            ok_reg[s] <= (win_reg == sig_reg[s]) || (LEN_W'(CELL_IDX) >= lens[s]);
        end
    end

    assign win_out = win_reg;
    assign sig_out = sig_reg;
    assign ok      = ok_reg;

endmodule

@@ hw/rtl/sbs_report.sv @@
// ----------------------------------------------------------------------------
// sbs_report
// Walks the match vector of one byte in slot order and drives the report
// stream through an output register.
// ----------------------------------------------------------------------------
module sbs_report #(
    parameter int NUM_SIGS = 8,
    parameter int SLOT_W   = 3,
    parameter int LEN_W    = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [NUM_SIGS-1:0]            match_vec,
    input  logic [15:0]                    count_in,
    input  logic [NUM_SIGS-1:0][LEN_W-1:0] lens,
    output logic                           busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // match_slot, start_offset, match_length
    output logic                           m_tlast
);
    import sbs_pkg::*;

    logic [NUM_SIGS-1:0] pend_reg;
    logic [RES_W-1:0]    nrep_reg;
    logic [15:0]         count_reg;
    logic                out_valid_reg;
    logic [2:0]          out_slot_reg;
    logic [15:0]         out_off_reg;
    logic [6:0]          out_len_reg;
    logic                out_last_reg;

    logic [NUM_SIGS-1:0] iso;
    logic [NUM_SIGS-1:0] rest;
    logic [SLOT_W-1:0]   pick;
    logic [LEN_W-1:0]    pick_len;
    logic                load;
    logic                pick_last;

    always_comb
    begin
        // lowest pending slot
        iso  = pend_reg & (~pend_reg + 1'b1);
        rest = pend_reg & ~iso;
        pick = '0;
        for (int s = 0; s < NUM_SIGS; s++)
        begin
            if (iso[s])
            begin
                pick = pick | SLOT_W'(s);
            end
        end
        pick_len  = lens[pick];
        load      = (pend_reg != '0) && (!out_valid_reg || m_tready);
        pick_last = (rest == '0) || (nrep_reg == RES_W'(MAX_RESULTS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            nrep_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                pend_reg <= match_vec;
                nrep_reg <= '0;
            end
            else if (load)
            begin
                pend_reg <= pick_last ? '0 : rest;
                nrep_reg <= nrep_reg + 1'b1;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            count_reg <= count_in;
        end
        if (load)
        begin
            out_slot_reg <= 3'(pick);
            out_off_reg  <= count_reg - 16'(pick_len);
            out_len_reg  <= 7'(pick_len);
            out_last_reg <= pick_last;
        end
    end

    assign busy     = (pend_reg != '0);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_len_reg, out_off_reg, out_slot_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ hw/rtl/sbs_checker.sv @@
// ----------------------------------------------------------------------------
// sbs_checker
// Port-level checks of the signature byte scanner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        pready
);

    // a stalled report beat holds
    `SBS_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "report changed while stalled")

    // a report never has zero length and never sets pad bits
    `SBS_ASSERT_CLK(a_len_nonzero, m_tvalid |-> (m_tdata[25:19] != 7'd0) && (m_tdata[31:26] == 6'd0), "bad report length or padding")

    // a fresh report comes only while the scan of a byte is still in progress
    `SBS_ASSERT_CLK(a_report_busy, $rose(m_tvalid) |-> !s_tready, "report appeared while input side idle")

    // register port never waits
    `SBS_ASSERT_CLK(a_pready, pready, "pready dropped")

endmodule

bind signature_byte_scanner sbs_checker u_sbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

@@ sim/tb_signature_byte_scanner.sv @@
// ----------------------------------------------------------------------------
// tb_signature_byte_scanner
// Self-checking bench for the signature byte scanner. A short table of
// directed beats is followed by randomised signature loads, scans that end on
// a stored signature, noise bytes and new streams, over several scan_limit
// settings. A behavioural predictor keeps its own signature store, window and
// stream position. Every report beat is compared field by field, in order,
// against the queue of predicted reports. Both streams idle at random, and
// the report side also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_signature_byte_scanner;
    import sbs_pkg::*;

    localparam int NSIG          = NUM_SIGS_DEF;
    localparam int SIGLEN        = MAX_SIG_LEN_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 2 * SIGLEN + 16;
    localparam int PHASE_BEATS   = 55;
    localparam int NUM_PHASES    = 5;
    localparam int DIR_ROWS      = 22;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [APB_ADDR_W-1:0] REG_SCAN_LIMIT = '0;

    typedef struct packed {
        logic [2:0]  slot;
        logic [15:0] offset;
        logic [6:0]  len;
        logic        is_last;
    } report_t;

    typedef struct {
        cmd_t cmd;
        int   slot;
        int   bidx;
        int   value;
        int   slen;
        int   exp_n;    // -1: predicted, otherwise number of reports written below
        int   e_slot;
        int   e_off;
        int   e_len;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // slot, byte_index, value, sig_length
    logic [1:0]            s_tuser;   // cmd
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // match_slot, start_offset, match_length
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // predictor state
    logic [7:0]  sig_bytes   [NSIG][SIGLEN];
    bit          sig_written [NSIG][SIGLEN];
    logic [6:0]  slot_len    [NSIG];
    logic [7:0]  scan_win    [SIGLEN];
    logic [15:0] stream_pos;
    logic [15:0] scan_limit_q;

    report_t expected_reports [$];
    report_t fresh_reports    [$];

    int fail_count    = 0;
    int counted_beats = 0;
    int send_idle     = 0;
    int recv_idle     = 0;
    int hold_cycles   = 0;
    int cycle_count   = 0;

    logic [15:0] phase_limit [NUM_PHASES] = '{16'hFFFF, 16'd0, 16'd20, 16'd3000, 16'hFFFF};
    int          phase_mode  [NUM_PHASES] = '{0, 0, 1, 1, 2};

    dir_row_t dir_tab [DIR_ROWS];

    signature_byte_scanner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t report %s mismatch: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic predict_reports(cmd_t c, int slot, int bidx, int value, int slen);
        int      count;
        int      n;
        int      len;
        int      s;
        int      k;
        bit      hit;
        report_t rep;
        fresh_reports.delete();
        case (c)
            CMD_WR_BYTE:
            begin
                sig_bytes[slot][bidx]   = 8'(value);
                sig_written[slot][bidx] = 1'b1;
            end
            CMD_SET_LEN:
                slot_len[slot] = (slen > SIGLEN) ? 7'(SIGLEN) : 7'(slen);
            CMD_NEW_STREAM:
            begin
                for (k = 0; k < SIGLEN; k++)
                    scan_win[k] = 8'h00;
                stream_pos = 16'd0;
            end
            default:
            begin
                if (stream_pos < scan_limit_q)
                begin
                    for (k = SIGLEN - 1; k > 0; k--)
                        scan_win[k] = scan_win[k - 1];
                    scan_win[0] = 8'(value);
                    count = int'(stream_pos) + 1;
                    n = 0;
                    for (s = 0; s < NSIG && n < MAX_RESULTS; s++)
                    begin
                        len = int'(slot_len[s]);
                        if (len == 0 || len > count)
                            continue;
                        hit = 1'b1;
                        // oldest window byte lines up with signature byte 0
                        for (k = 0; k < len; k++)
                            if (sig_bytes[s][k] != scan_win[len - 1 - k])
                                hit = 1'b0;
                        if (!hit)
                            continue;
                        rep.slot    = 3'(s);
                        rep.offset  = 16'(count - len);
                        rep.len     = 7'(len);
                        rep.is_last = 1'b0;
                        fresh_reports.push_back(rep);
                        n++;
                    end
                    if (n > 0)
                        fresh_reports[n - 1].is_last = 1'b1;
                    stream_pos = 16'(count);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // input stream
    // ------------------------------------------------------------------
    task automatic send_beat(cmd_t c, int slot, int bidx, int value, int slen, bit use_model);
        bit taken;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {7'(slen), 8'(value), 6'(bidx), 3'(slot)};
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        counted_beats++;
        predict_reports(c, slot, bidx, value, slen);
        if (use_model)
            foreach (fresh_reports[i])
                expected_reports.push_back(fresh_reports[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        // a length beat may still be rotating the cell chain
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // apb
    // ------------------------------------------------------------------
    task automatic write_scan_limit(logic [15:0] lim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SCAN_LIMIT;
        pwdata  <= {16'h0000, lim};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        scan_limit_q = lim;
        // bus returns to idle before the next transfer
        @(posedge clk);
    endtask

    task automatic check_scan_limit();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_SCAN_LIMIT;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got != {16'h0000, scan_limit_q})
        begin
            fail_count++;
            $display("%0t scan_limit read mismatch: expected %0d actual %0d",
                     $time, scan_limit_q, got);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_byte();
        // narrow alphabet most of the time so that signatures overlap
        if ($urandom_range(0, 99) < 60)
            return 8'h41 + $urandom_range(0, 2);
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_enabled_slot();
        int base;
        int s;
        base = $urandom_range(0, NSIG - 1);
        for (int i = 0; i < NSIG; i++)
        begin
            s = (base + i) % NSIG;
            if (slot_len[s] != 0)
                return s;
        end
        return -1;
    endfunction

    task automatic load_signature(int s, int len);
        int slen;
        for (int k = 0; k < len; k++)
            send_beat(CMD_WR_BYTE, s, k, pick_byte(), $urandom_range(0, 127), 1'b1);
        slen = len;
        if (len == SIGLEN && $urandom_range(0, 1))
            slen = $urandom_range(SIGLEN, 127);
        send_beat(CMD_SET_LEN, s, $urandom_range(0, 63), $urandom_range(0, 255), slen, 1'b1);
    endtask

    task automatic scan_signature(int s);
        int         len;
        logic [7:0] snap [SIGLEN];
        len  = int'(slot_len[s]);
        snap = sig_bytes[s];
        repeat ($urandom_range(0, 3))
            send_beat(CMD_SCAN, $urandom_range(0, 7), $urandom_range(0, 63), pick_byte(),
                      $urandom_range(0, 127), 1'b1);
        for (int k = 0; k < len; k++)
            send_beat(CMD_SCAN, $urandom_range(0, 7), $urandom_range(0, 63), snap[k],
                      $urandom_range(0, 127), 1'b1);
    endtask

    // every slot gets the same one-byte signature, so each scan of it fills the output
    task automatic all_slots_same(int scans);
        int b;
        b = pick_byte();
        for (int s = 0; s < NSIG; s++)
        begin
            send_beat(CMD_WR_BYTE, s, 0, b, $urandom_range(0, 127), 1'b1);
            send_beat(CMD_SET_LEN, s, $urandom_range(0, 63), $urandom_range(0, 255), 1, 1'b1);
        end
        repeat (scans)
            send_beat(CMD_SCAN, $urandom_range(0, 7), $urandom_range(0, 63), b,
                      $urandom_range(0, 127), 1'b1);
    endtask

    // new length bounded by the written prefix of the slot
    task automatic tweak_length();
        int s;
        int p;
        int len;
        s = $urandom_range(0, NSIG - 1);
        p = 0;
        while (p < SIGLEN && sig_written[s][p])
            p++;
        len = $urandom_range(0, p);
        if (len == SIGLEN && $urandom_range(0, 1))
            len = $urandom_range(SIGLEN, 127);
        send_beat(CMD_SET_LEN, s, $urandom_range(0, 63), $urandom_range(0, 255), len, 1'b1);
    endtask

    task automatic random_action();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 25)
            load_signature($urandom_range(0, NSIG - 1),
                           ($urandom_range(0, 9) == 0) ? SIGLEN : $urandom_range(1, 6));
        else if (r < 60)
        begin
            s = pick_enabled_slot();
            if (s < 0)
                load_signature($urandom_range(0, NSIG - 1), $urandom_range(1, 6));
            else
                scan_signature(s);
        end
        else if (r < 75)
            repeat ($urandom_range(1, 8))
                send_beat(CMD_SCAN, $urandom_range(0, 7), $urandom_range(0, 63),
                          $urandom_range(0, 1) ? pick_byte() : $urandom_range(0, 255),
                          $urandom_range(0, 127), 1'b1);
        else if (r < 82)
            send_beat(CMD_NEW_STREAM, $urandom_range(0, 7), $urandom_range(0, 63),
                      $urandom_range(0, 255), $urandom_range(0, 127), 1'b1);
        else if (r < 89)
            tweak_length();
        else if (r < 95)
            send_beat(CMD_WR_BYTE, $urandom_range(0, 7), $urandom_range(0, 63),
                      $urandom_range(0, 255), $urandom_range(0, 127), 1'b1);
        else
            all_slots_same($urandom_range(1, 3));
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            0:
            begin
                send_idle = 15;
                recv_idle = 76;
            end
            1:
            begin
                send_idle = 76;
                recv_idle = 15;
            end
            default:
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // report stream
    // ------------------------------------------------------------------
    initial
    begin : report_sink
        report_t want;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            @(negedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected report beat: expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("match_slot", want.slot, m_tdata[2:0]);
                    check_field("start_offset", want.offset, m_tdata[18:3]);
                    check_field("match_length", want.len, m_tdata[25:19]);
                    check_field("last", want.is_last, m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        dir_row_t row;
        report_t  rep;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_WR_BYTE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;

        for (int s = 0; s < NSIG; s++)
        begin
            slot_len[s] = 7'd0;
            for (int k = 0; k < SIGLEN; k++)
            begin
                sig_bytes[s][k]   = 8'h00;
                sig_written[s][k] = 1'b0;
            end
        end
        for (int k = 0; k < SIGLEN; k++)
            scan_win[k] = 8'h00;
        stream_pos   = 16'd0;
        scan_limit_q = SCAN_LIMIT_RST;

        dir_tab = '{
            // nothing enabled after reset
            '{CMD_SCAN,       0,  0, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_WR_BYTE,    0,  0, 8'hFF,   0,  0, 0, 0, 0},
            '{CMD_WR_BYTE,    0,  1, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_SET_LEN,    0,  0, 8'h00,   2,  0, 0, 0, 0},
            '{CMD_SCAN,       0,  0, 8'hFF,   0,  0, 0, 0, 0},
            '{CMD_SCAN,       0,  0, 8'h00,   0,  1, 0, 1, 2},
            '{CMD_WR_BYTE,    1,  0, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_WR_BYTE,    1,  1, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_SET_LEN,    1,  0, 8'h00,   2,  0, 0, 0, 0},
            '{CMD_NEW_STREAM, 0,  0, 8'h00,   0,  0, 0, 0, 0},
            // all-zero signature cannot match before two bytes are in
            '{CMD_SCAN,       0,  0, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_SCAN,       0,  0, 8'h00,   0,  1, 1, 0, 2},
            '{CMD_WR_BYTE,    7, 63, 8'hAA, 127,  0, 0, 0, 0},
            '{CMD_WR_BYTE,    2,  0, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_SET_LEN,    2,  0, 8'h00,   1,  0, 0, 0, 0},
            '{CMD_SCAN,       0,  0, 8'h00,   0, -1, 0, 0, 0},
            '{CMD_SET_LEN,    0,  0, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_SCAN,       0,  0, 8'hFF,   0, -1, 0, 0, 0},
            '{CMD_SCAN,       0,  0, 8'h00,   0, -1, 0, 0, 0},
            '{CMD_NEW_STREAM, 7, 63, 8'hFF, 127,  0, 0, 0, 0},
            '{CMD_SET_LEN,    1,  0, 8'h00,   0,  0, 0, 0, 0},
            '{CMD_SET_LEN,    2,  0, 8'h00,   0,  0, 0, 0, 0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle_mode(phase_mode[0]);
        check_scan_limit();

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = dir_tab[i];
            send_beat(row.cmd, row.slot, row.bidx, row.value, row.slen, row.exp_n < 0);
            if (row.exp_n > 0)
            begin
                rep = '{slot: 3'(row.e_slot), offset: 16'(row.e_off),
                        len: 7'(row.e_len), is_last: 1'b1};
                expected_reports.push_back(rep);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            write_scan_limit(phase_limit[ph]);
            check_scan_limit();
            set_idle_mode(phase_mode[ph]);
            counted_beats = 0;
            if (ph == 0)
            begin
                // long receiver stall while full reports keep coming
                hold_cycles = HOLD_CYCLES;
                all_slots_same(4);
                load_signature($urandom_range(0, NSIG - 1), SIGLEN);
                scan_signature(pick_enabled_slot());
                // sender waits for every report before going on
                wait_drained();
            end
            while (counted_beats < PHASE_BEATS)
                random_action();
        end

        wait_drained();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_cell.sv
hw/rtl/sbs_report.sv
hw/rtl/signature_byte_scanner.sv
hw/rtl/sbs_checker.sv
sim/tb_signature_byte_scanner.sv
